>>> src/assert_macros.svh
// Assertion macros used by the top level of the dependency depth tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DDT_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`define DDT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define DDT_ASSERT_IMP(label, clk, rst_n, pre, post, msg)

`define DDT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

>>> src/ddt_pkg.sv
// Package of the dependency depth tracker: function codes and parameter defaults.
`default_nettype none

package ddt_pkg;

    localparam int DEF_NUM_REGS    = 32;
    localparam int DEF_NUM_OPCODES = 32;
    localparam int DEF_INDEX_WIDTH = 16;
    localparam int DEF_DEPTH_WIDTH = 24;

    localparam int FUNC_WIDTH   = 2;
    localparam int FIELD_WIDTH  = 5;
    localparam int LAT_WIDTH    = 8;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_ANALYZE = 2'd1,
        FUNC_CLEAR   = 2'd2
    } func_t;

endpackage

`default_nettype wire

>>> src/dataflow_dependency_depth_tracker.sv
// Top level of the register dependency depth tracker.
// Usage: instruction transactions enter on in_valid/in_stall with func, opcode,
// dest_reg, source_a_reg, source_b_reg and latency_value. func load writes the
// opcode latency table, func analyze scores one instruction, func clear starts
// a new program (latency table kept). Only analyze yields a result transaction
// on out_valid/out_stall: index, depth, both producers (all ones = entry) and
// running program depth.
// Pipeline: an accepted transaction is registered in the input stage while the
// table and producer memories are read; an analyze then loads the output
// register once it is free. The memories are written as the transaction leaves
// the input stage; a one-deep forward path covers the write-then-read case.
// Throughput: one transaction per cycle while no analyze waits on a held result
// register; the read-max-add-write pass over the producer table never holds it.
// Reset: all register producers return to entry, counters and program depth
// clear at once; the latency table is undefined until loaded.
// Stall: while out_stall holds a result, the output register holds; a waiting
// analyze stalls the input, load and clear transactions still pass.
`default_nettype none

module dataflow_dependency_depth_tracker
    import ddt_pkg::*;
#(
    parameter int NUM_REGS    = DEF_NUM_REGS,
    parameter int NUM_OPCODES = DEF_NUM_OPCODES,
    parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
    parameter int DEPTH_WIDTH = DEF_DEPTH_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [FUNC_WIDTH-1:0]         func,
    input  wire logic [FIELD_WIDTH-1:0]        opcode,
    input  wire logic [FIELD_WIDTH-1:0]        dest_reg,
    input  wire logic [FIELD_WIDTH-1:0]        source_a_reg,
    input  wire logic [FIELD_WIDTH-1:0]        source_b_reg,
    input  wire logic [LAT_WIDTH-1:0]          latency_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic        [INDEX_WIDTH-1:0]      inst_index,
    output logic        [DEPTH_WIDTH-1:0]      inst_depth,
    output logic signed [INDEX_WIDTH:0]        src_a_producer,
    output logic signed [INDEX_WIDTH:0]        src_b_producer,
    output logic        [DEPTH_WIDTH-1:0]      program_depth
);

`include "assert_macros.svh"

    localparam int RAW    = $clog2(NUM_REGS);
    localparam int OAW    = $clog2(NUM_OPCODES);
    localparam int WORD_W = INDEX_WIDTH + DEPTH_WIDTH;

    // input stage
    logic                    s1_valid_reg;
    logic [FUNC_WIDTH-1:0]   s1_func_reg;
    logic [FIELD_WIDTH-1:0]  s1_opcode_reg;
    logic [FIELD_WIDTH-1:0]  s1_dest_reg;
    logic [FIELD_WIDTH-1:0]  s1_sa_reg;
    logic [FIELD_WIDTH-1:0]  s1_sb_reg;
    logic [LAT_WIDTH-1:0]    s1_lat_reg;
    logic                    fwd_a_reg;
    logic                    fwd_b_reg;
    logic                    fwd_lat_reg;
    logic [WORD_W-1:0]       fwd_word_reg;
    logic [LAT_WIDTH-1:0]    fwd_lat_data_reg;

    // program state
    logic [NUM_REGS-1:0]     writer_valid_reg;
    logic [INDEX_WIDTH-1:0]  inst_count_reg;
    logic [DEPTH_WIDTH-1:0]  max_depth_reg;

    // result register
    logic                    res_valid_reg;
    logic [INDEX_WIDTH-1:0]  res_index_reg;
    logic [DEPTH_WIDTH-1:0]  res_depth_reg;
    logic [INDEX_WIDTH:0]    res_prod_a_reg;
    logic [INDEX_WIDTH:0]    res_prod_b_reg;
    logic [DEPTH_WIDTH-1:0]  res_max_reg;

    logic                    in_accept;
    logic                    res_free;
    logic                    s1_fire;
    logic                    analyze_fire;
    logic                    load_fire;
    logic                    clear_fire;
    logic                    word_wr_en;
    logic [RAW-1:0]          word_wr_addr;
    logic [WORD_W-1:0]       word_wr_data;
    logic                    lat_wr_en;
    logic [OAW-1:0]          lat_wr_addr;
    logic [WORD_W-1:0]       ram_a_rdata;
    logic [WORD_W-1:0]       ram_b_rdata;
    logic [LAT_WIDTH-1:0]    ram_lat_rdata;
    logic [WORD_W-1:0]       word_a;
    logic [WORD_W-1:0]       word_b;
    logic                    va;
    logic                    vb;
    logic                    dest_in_range;
    logic                    op_in_range;
    logic [DEPTH_WIDTH-1:0]  ready_a;
    logic [DEPTH_WIDTH-1:0]  ready_b;
    logic [DEPTH_WIDTH-1:0]  depth;
    logic [LAT_WIDTH-1:0]    lat;
    logic [DEPTH_WIDTH:0]    sum;
    logic [DEPTH_WIDTH-1:0]  ready;
    logic [DEPTH_WIDTH-1:0]  max_depth_next;
    logic [INDEX_WIDTH:0]    prod_a;
    logic [INDEX_WIDTH:0]    prod_b;

    assign res_free     = !res_valid_reg || !out_stall;
    assign s1_fire      = s1_valid_reg && ((s1_func_reg != FUNC_ANALYZE) || res_free);
    assign in_stall     = s1_valid_reg && !s1_fire;
    assign in_accept    = in_valid && !in_stall;
    assign analyze_fire = s1_fire && (s1_func_reg == FUNC_ANALYZE);
    assign load_fire    = s1_fire && (s1_func_reg == FUNC_LOAD);
    assign clear_fire   = s1_fire && (s1_func_reg == FUNC_CLEAR);

    assign dest_in_range = 32'(s1_dest_reg) < NUM_REGS;
    assign op_in_range   = 32'(s1_opcode_reg) < NUM_OPCODES;

    assign word_wr_en   = analyze_fire && dest_in_range;
    assign word_wr_addr = RAW'(s1_dest_reg);
    assign word_wr_data = {inst_count_reg, ready};
    assign lat_wr_en    = load_fire && op_in_range;
    assign lat_wr_addr  = OAW'(s1_opcode_reg);

    ddt_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_ram_a (
        .clk     (clk),
        .wr_en   (word_wr_en),
        .wr_addr (word_wr_addr),
        .wr_data (word_wr_data),
        .rd_en   (in_accept),
        .rd_addr (RAW'(source_a_reg)),
        .rd_data (ram_a_rdata)
    );

    ddt_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_ram_b (
        .clk     (clk),
        .wr_en   (word_wr_en),
        .wr_addr (word_wr_addr),
        .wr_data (word_wr_data),
        .rd_en   (in_accept),
        .rd_addr (RAW'(source_b_reg)),
        .rd_data (ram_b_rdata)
    );

    ddt_ram #(.WIDTH(LAT_WIDTH), .DEPTH(NUM_OPCODES)) u_ram_lat (
        .clk     (clk),
        .wr_en   (lat_wr_en),
        .wr_addr (lat_wr_addr),
        .wr_data (s1_lat_reg),
        .rd_en   (in_accept),
        .rd_addr (OAW'(opcode)),
        .rd_data (ram_lat_rdata)
    );

    always_comb
    begin
        word_a  = fwd_a_reg ? fwd_word_reg : ram_a_rdata;
        word_b  = fwd_b_reg ? fwd_word_reg : ram_b_rdata;
        va      = (32'(s1_sa_reg) < NUM_REGS) && writer_valid_reg[RAW'(s1_sa_reg)];
        vb      = (32'(s1_sb_reg) < NUM_REGS) && writer_valid_reg[RAW'(s1_sb_reg)];
        ready_a = va ? word_a[DEPTH_WIDTH-1:0] : '0;
        ready_b = vb ? word_b[DEPTH_WIDTH-1:0] : '0;
        prod_a  = va ? {1'b0, word_a[WORD_W-1:DEPTH_WIDTH]} : '1;
        prod_b  = vb ? {1'b0, word_b[WORD_W-1:DEPTH_WIDTH]} : '1;
        depth   = (ready_a > ready_b) ? ready_a : ready_b;
        lat     = op_in_range ? (fwd_lat_reg ? fwd_lat_data_reg : ram_lat_rdata) : '0;
        sum     = {1'b0, depth} + (DEPTH_WIDTH+1)'(lat);
        ready   = sum[DEPTH_WIDTH] ? '1 : sum[DEPTH_WIDTH-1:0];
        max_depth_next = (ready > max_depth_reg) ? ready : max_depth_reg;
    end

    // advance the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg      <= func;
            s1_opcode_reg    <= opcode;
            s1_dest_reg      <= dest_reg;
            s1_sa_reg        <= source_a_reg;
            s1_sb_reg        <= source_b_reg;
            s1_lat_reg       <= latency_value;
            fwd_a_reg        <= word_wr_en && (word_wr_addr == RAW'(source_a_reg));
            fwd_b_reg        <= word_wr_en && (word_wr_addr == RAW'(source_b_reg));
            fwd_word_reg     <= word_wr_data;
            fwd_lat_reg      <= lat_wr_en && (lat_wr_addr == OAW'(opcode));
            fwd_lat_data_reg <= s1_lat_reg;
        end
    end

    // update program state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writer_valid_reg <= '0;
            inst_count_reg   <= '0;
            max_depth_reg    <= '0;
        end
        else if (clear_fire)
        begin
            writer_valid_reg <= '0;
            inst_count_reg   <= '0;
            max_depth_reg    <= '0;
        end
        else if (analyze_fire)
        begin
            if (dest_in_range)
            begin
                writer_valid_reg[RAW'(s1_dest_reg)] <= 1'b1;
            end
            inst_count_reg <= inst_count_reg + 1'b1;
            max_depth_reg  <= max_depth_next;
        end
    end

    // hold or load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= analyze_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (analyze_fire)
        begin
            res_index_reg  <= inst_count_reg;
            res_depth_reg  <= depth;
            res_prod_a_reg <= prod_a;
            res_prod_b_reg <= prod_b;
            res_max_reg    <= max_depth_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign inst_index     = res_index_reg;
    assign inst_depth     = res_depth_reg;
    assign src_a_producer = res_prod_a_reg;
    assign src_b_producer = res_prod_b_reg;
    assign program_depth  = res_max_reg;

    `DDT_ASSERT_NEXT(a_count_step, clk, rst_n, analyze_fire, inst_count_reg == INDEX_WIDTH'($past(inst_count_reg) + 1'b1), "instruction index did not advance")
    `DDT_ASSERT_NEXT(a_clear_state, clk, rst_n, clear_fire, (writer_valid_reg == '0) && (max_depth_reg == '0), "new program left stale state")
    `DDT_ASSERT_IMP(a_depth_order, clk, rst_n, out_valid, program_depth >= inst_depth, "program depth below instruction depth")

endmodule

`default_nettype wire

>>> src/ddt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ddt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire
